>>> rtl/sfrp_pkg.sv
// Shared types, codes and decode functions for the sensor FIFO record parser.
// No dependencies; imported by the parser and the top level.
package sfrp_pkg;

  localparam int PAY_BYTES = 10;
  localparam int TIME_W    = 40;

  localparam logic [2:0] MODE_TAG   = 3'd0;
  localparam logic [2:0] MODE_SKIP  = 3'd1;
  localparam logic [2:0] MODE_SMALL = 3'd2;
  localparam logic [2:0] MODE_LARGE = 3'd3;
  localparam logic [2:0] MODE_FULL  = 3'd4;
  localparam logic [2:0] MODE_QUAT  = 3'd5;
  localparam logic [2:0] MODE_EULER = 3'd6;
  localparam logic [2:0] MODE_VECT  = 3'd7;

  localparam logic [1:0] FMT_QUAT  = 2'd0;
  localparam logic [1:0] FMT_EULER = 2'd1;
  localparam logic [1:0] FMT_VECT  = 2'd2;

  typedef struct packed {
    logic [7:0]        sensor_id;
    logic [1:0]        record_format;
    logic [TIME_W-1:0] timestamp;
    logic [15:0]       x_value;
    logic [15:0]       y_value;
    logic [15:0]       z_value;
    logic [15:0]       w_value;
    logic [15:0]       accuracy;
  } rec_t;

  function automatic logic [2:0] tag_mode(input logic [7:0] b);
    logic [2:0] m;
    m = MODE_TAG;
    case (b) inside
      8'hfb, 8'hf5: m = MODE_SMALL;
      8'hfc, 8'hf6: m = MODE_LARGE;
      8'hfd, 8'hf7: m = MODE_FULL;
      8'hfe, 8'hf8: m = MODE_SKIP;
      8'd34, 8'd35, 8'd37, 8'd38, 8'd40, 8'd41: m = MODE_QUAT;
      8'd43, 8'd44: m = MODE_EULER;
      8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd10, 8'd12, 8'd13, 8'd14,
      8'd15, 8'd16, 8'd19, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd28,
      8'd29, 8'd31, 8'd32, 8'd91, 8'd92, 8'd93: m = MODE_VECT;
      default: m = MODE_TAG;
    endcase
    return m;
  endfunction

  // Number of bytes that follow the tag byte.
  function automatic logic [3:0] mode_len(input logic [2:0] m);
    logic [3:0] n;
    case (m)
      MODE_SMALL: n = 4'd1;
      MODE_LARGE: n = 4'd2;
      MODE_SKIP:  n = 4'd3;
      MODE_FULL:  n = 4'd5;
      MODE_QUAT:  n = 4'd10;
      MODE_EULER: n = 4'd6;
      MODE_VECT:  n = 4'd6;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/sfrp_parser.sv
// Byte-wise record parser: tag decode, payload collection and tick time.
// Depends on sfrp_pkg.
module sfrp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          res_valid,
  output sfrp_pkg::rec_t res
);
  import sfrp_pkg::*;

  logic [2:0]                mode_r,  mode_nxt;
  logic [3:0]                left_r,  left_nxt;
  logic [7:0]                tag_r,   tag_nxt;
  logic [PAY_BYTES-1:0][7:0] pl_r,    pl_nxt;
  logic [TIME_W-1:0]         tick_r,  tick_nxt;
  logic [2:0]                dec_mode;
  logic [3:0]                idx;
  logic [3:0]                left_dec;
  logic [PAY_BYTES-1:0][7:0] pl_wr;
  logic                      tag_phase;

  always_comb begin
    dec_mode  = tag_mode(in_byte);
    tag_phase = (mode_r == MODE_TAG) || (left_r == 4'd0);
    idx       = mode_len(mode_r) - left_r;
    left_dec  = left_r - 4'd1;
    pl_wr     = pl_r;
    if (mode_r != MODE_SKIP) begin
      pl_wr[idx] = in_byte;
    end

    mode_nxt  = mode_r;
    left_nxt  = left_r;
    tag_nxt   = tag_r;
    pl_nxt    = pl_r;
    tick_nxt  = tick_r;
    res_valid = 1'b0;

    res.sensor_id     = tag_r;
    res.timestamp     = tick_r;
    res.x_value       = {pl_wr[1], pl_wr[0]};
    res.y_value       = {pl_wr[3], pl_wr[2]};
    res.z_value       = {pl_wr[5], pl_wr[4]};
    res.w_value       = 16'd0;
    res.accuracy      = 16'd0;
    res.record_format = FMT_VECT;
    case (mode_r)
      MODE_QUAT: begin
        res.record_format = FMT_QUAT;
        res.w_value       = {pl_wr[7], pl_wr[6]};
        res.accuracy      = {pl_wr[9], pl_wr[8]};
      end
      MODE_EULER: res.record_format = FMT_EULER;
      default:    res.record_format = FMT_VECT;
    endcase

    if (in_fire) begin
      if (tag_phase) begin
        mode_nxt = MODE_TAG;
        if (dec_mode != MODE_TAG) begin
          mode_nxt = dec_mode;
          left_nxt = mode_len(dec_mode);
          tag_nxt  = in_byte;
          pl_nxt   = '0;
        end
      end else begin
        pl_nxt   = pl_wr;
        left_nxt = left_dec;
        if (left_dec == 4'd0) begin
          mode_nxt = MODE_TAG;
          case (mode_r)
            MODE_SMALL: tick_nxt = tick_r + {32'd0, pl_wr[0]};
            MODE_LARGE: tick_nxt = tick_r + {24'd0, pl_wr[1], pl_wr[0]};
            MODE_FULL:  tick_nxt = {pl_wr[4], pl_wr[3], pl_wr[2], pl_wr[1], pl_wr[0]};
            MODE_QUAT, MODE_EULER, MODE_VECT: res_valid = 1'b1;
            default: tick_nxt = tick_r;
          endcase
        end
      end
      // The last byte of a read is processed first, then everything restarts.
      if (in_last) begin
        mode_nxt = MODE_TAG;
        left_nxt = 4'd0;
        tag_nxt  = 8'd0;
        pl_nxt   = '0;
        tick_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TAG;
      left_r <= 4'd0;
      tag_r  <= 8'd0;
      tick_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      tag_r  <= tag_nxt;
      tick_r <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pl_r <= pl_nxt;
  end

endmodule

>>> rtl/sensor_fifo_record_parser_core.sv
// Top level of the sensor FIFO record parser: stream ports and output skid.
// Depends on sfrp_pkg and sfrp_parser.
//
// The block takes one FIFO byte per cycle while not stalled and emits one record request
// when the last payload byte of a quaternion, Euler or vector record arrives, stamped
// with the running tick time. Each byte is fully handled in the cycle it is accepted,
// so the sustained rate is one byte per cycle when not stalled; a finished record is
// registered into the output register, or into the skid register while the output is
// held. The output register, backed by the one-entry skid register, keeps the input open
// while a record waits; the input stalls only when both are full. Asserting in_tlast on
// a byte processes it and then clears the parser and the time.
module sensor_fifo_record_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tlast,   // end_of_read
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // sensor_id[7:0], timestamp[47:8], x_value[63:48],
                                   // y_value[79:64], z_value[95:80], w_value[111:96],
                                   // accuracy[127:112]
  output logic [1:0]   out_tuser   // record_format[1:0]
);
  import sfrp_pkg::*;

  logic in_fire;
  logic res_valid;
  rec_t res;
  logic out_v_r,  out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  rec_t out_r,    out_nxt;
  rec_t skid_r,   skid_nxt;
  logic slot_free;

  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;

  sfrp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    slot_free  = !out_v_r || out_tready;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (slot_free) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.record_format;
  assign out_tdata  = {out_r.accuracy, out_r.w_value, out_r.z_value, out_r.y_value,
                       out_r.x_value, out_r.timestamp, out_r.sensor_id};

endmodule

>>> rtl/sfrp_checker.sv
// Port-level checks for the sensor FIFO record parser, with its bind statement.
// Depends on sfrp_pkg and on sensor_fifo_record_parser_core being compiled first.
module sfrp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]   out_tuser
);
  import sfrp_pkg::*;

  a_fmt_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == FMT_QUAT || out_tuser == FMT_EULER || out_tuser == FMT_VECT))
    else $error("record format out of range");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != FMT_QUAT) |-> (out_tdata[127:96] == 32'd0))
    else $error("non-quaternion request carries w or accuracy");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output request changed");

endmodule

bind sensor_fifo_record_parser_core sfrp_checker u_sfrp_checker (.*);

>>> verif/sensor_fifo_record_parser_core_tb.sv
// Self-checking testbench for sensor_fifo_record_parser_core: FIFO byte streams in, parsed
// sensor records out, each checked against a byte-level predictor or a hand-written record.
// Depends on sfrp_pkg and the parser RTL.
module sensor_fifo_record_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1500;

  localparam logic [7:0] TAG_PAD      = 8'h00;
  localparam logic [7:0] TAG_FILLER   = 8'hff;
  localparam logic [7:0] TAG_SMALL0   = 8'hfb;
  localparam logic [7:0] TAG_SMALL1   = 8'hf5;
  localparam logic [7:0] TAG_LARGE0   = 8'hfc;
  localparam logic [7:0] TAG_LARGE1   = 8'hf6;
  localparam logic [7:0] TAG_FULL0    = 8'hfd;
  localparam logic [7:0] TAG_FULL1    = 8'hf7;
  localparam logic [7:0] TAG_META0    = 8'hfe;
  localparam logic [7:0] TAG_META1    = 8'hf8;
  localparam logic [7:0] TAG_UNKNOWN  = 8'h02;
  localparam logic [7:0] TAG_ACCEL    = 8'd1;
  localparam logic [7:0] TAG_ROTATION = 8'd34;
  localparam logic [7:0] TAG_ORIENT   = 8'd43;

  localparam logic [5:0][7:0] QUAT_TAGS = {8'd34, 8'd35, 8'd37, 8'd38, 8'd40, 8'd41};
  localparam logic [1:0][7:0] EULER_TAGS = {8'd43, 8'd44};
  localparam logic [24:0][7:0] VECT_TAGS = {
    8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd10, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16,
    8'd19, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd28, 8'd29, 8'd31, 8'd32, 8'd91,
    8'd92, 8'd93};

  localparam rec_t NO_REC = '0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    rec_t       rec;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;

  logic [2:0]                  cur_mode;
  logic [3:0]                  bytes_to_go;
  logic [7:0]                  rec_tag;
  logic [PAY_BYTES-1:0][7:0]   payload;
  logic [TIME_W-1:0]           tick;

  rec_t       pending_records[$];
  logic [7:0] read_bytes[$];
  rec_t       got;
  rec_t       want;
  int         errors;
  int         cycle_count;
  bit         idle_on;
  bit         hold_req;

  dir_row_t dir_rows [36] = '{
    '{TAG_ACCEL, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b1,
      '{TAG_ACCEL, FMT_VECT, 40'd0, 16'hffff, 16'h0000, 16'h00ff, 16'h0000, 16'h0000}},
    '{TAG_FILLER, 1'b0, 1'b0, NO_REC},
    '{TAG_PAD, 1'b0, 1'b0, NO_REC},
    '{TAG_UNKNOWN, 1'b0, 1'b0, NO_REC},
    '{TAG_FULL0, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{8'hff, 1'b0, 1'b0, NO_REC},
    '{TAG_SMALL0, 1'b0, 1'b0, NO_REC},
    '{8'h02, 1'b0, 1'b0, NO_REC},
    '{TAG_LARGE1, 1'b0, 1'b0, NO_REC},
    '{8'h03, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, NO_REC},
    '{TAG_META1, 1'b0, 1'b0, NO_REC},
    '{TAG_ROTATION, 1'b0, 1'b0, NO_REC},
    '{TAG_ROTATION, 1'b0, 1'b0, NO_REC},
    '{TAG_ROTATION, 1'b0, 1'b0, NO_REC},
    '{TAG_ORIENT, 1'b0, 1'b0, NO_REC},
    '{8'h34, 1'b0, 1'b0, NO_REC},
    '{8'h12, 1'b0, 1'b0, NO_REC},
    '{8'h78, 1'b0, 1'b0, NO_REC},
    '{8'h56, 1'b0, 1'b0, NO_REC},
    '{8'hbc, 1'b0, 1'b0, NO_REC},
    '{8'h9a, 1'b1, 1'b1,
      '{TAG_ORIENT, FMT_EULER, 40'd4, 16'h1234, 16'h5678, 16'h9abc, 16'h0000, 16'h0000}},
    '{TAG_ROTATION, 1'b0, 1'b0, NO_REC},
    '{8'h11, 1'b0, 1'b0, NO_REC},
    '{8'h22, 1'b0, 1'b0, NO_REC},
    '{8'h33, 1'b1, 1'b0, NO_REC}
  };

  sensor_fifo_record_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void clear_parser();
    cur_mode    = MODE_TAG;
    bytes_to_go = 4'd0;
    rec_tag     = 8'd0;
    payload     = '0;
    tick        = '0;
  endfunction

  // Advances the parser state by one FIFO byte; returns 1 when a record completes.
  function automatic bit parse_byte(input logic [7:0] b, input logic eor, output rec_t r);
    int         len;
    int         idx;
    int         i;
    logic [2:0] m;
    bit         emitted;
    emitted = 1'b0;
    r = '0;
    if (cur_mode == MODE_TAG || bytes_to_go == 4'd0) begin
      cur_mode = MODE_TAG;
      m = MODE_TAG;
      len = 0;
      case (b)
        TAG_SMALL0, TAG_SMALL1: begin
          m = MODE_SMALL;
          len = 1;
        end
        TAG_LARGE0, TAG_LARGE1: begin
          m = MODE_LARGE;
          len = 2;
        end
        TAG_FULL0, TAG_FULL1: begin
          m = MODE_FULL;
          len = 5;
        end
        TAG_META0, TAG_META1: begin
          m = MODE_SKIP;
          len = 3;
        end
        default: begin
          for (i = 0; i < 6; i++) begin
            if (QUAT_TAGS[i[2:0]] == b) begin
              m = MODE_QUAT;
              len = 10;
            end
          end
          for (i = 0; i < 2; i++) begin
            if (EULER_TAGS[i[0]] == b) begin
              m = MODE_EULER;
              len = 6;
            end
          end
          for (i = 0; i < 25; i++) begin
            if (VECT_TAGS[i[4:0]] == b) begin
              m = MODE_VECT;
              len = 6;
            end
          end
        end
      endcase
      if (m != MODE_TAG) begin
        cur_mode    = m;
        bytes_to_go = len[3:0];
        rec_tag     = b;
        payload     = '0;
      end
    end else begin
      case (cur_mode)
        MODE_SMALL:            len = 1;
        MODE_LARGE:            len = 2;
        MODE_FULL:             len = 5;
        MODE_QUAT:             len = 10;
        MODE_EULER, MODE_VECT: len = 6;
        default:               len = 0;
      endcase
      idx = (len >= int'(bytes_to_go)) ? len - int'(bytes_to_go) : 0;
      if (cur_mode != MODE_SKIP && idx < PAY_BYTES) payload[idx[3:0]] = b;
      bytes_to_go = bytes_to_go - 4'd1;
      if (bytes_to_go == 4'd0) begin
        m = cur_mode;
        cur_mode = MODE_TAG;
        case (m)
          MODE_SMALL: tick = tick + {32'd0, payload[0]};
          MODE_LARGE: tick = tick + {24'd0, payload[1], payload[0]};
          MODE_FULL:  tick = {payload[4], payload[3], payload[2], payload[1], payload[0]};
          MODE_QUAT, MODE_EULER, MODE_VECT: begin
            r.sensor_id     = rec_tag;
            r.record_format = (m == MODE_QUAT) ? FMT_QUAT :
                              (m == MODE_EULER) ? FMT_EULER : FMT_VECT;
            r.timestamp     = tick;
            r.x_value       = {payload[1], payload[0]};
            r.y_value       = {payload[3], payload[2]};
            r.z_value       = {payload[5], payload[4]};
            if (m == MODE_QUAT) begin
              r.w_value  = {payload[7], payload[6]};
              r.accuracy = {payload[9], payload[8]};
            end
            emitted = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (eor) clear_parser();
    return emitted;
  endfunction

  task automatic offer(input logic [7:0] b, input logic eor, input logic typed,
                       input rec_t typed_rec);
    rec_t predicted;
    bit   emitted;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eor;
    do @(posedge clk); while (!in_tready);
    emitted = parse_byte(b, eor, predicted);
    if (typed) pending_records.push_back(typed_rec);
    else if (emitted) pending_records.push_back(predicted);
  endtask

  // Builds one FIFO read of mostly well-formed records; returns the count of
  // bytes that belong to records rather than filler, counted before the read is cut short.
  task automatic build_read(output int useful);
    int         kind;
    int         plen;
    int         style;
    int         cut;
    logic [7:0] tag;
    read_bytes.delete();
    useful = 0;
    repeat ($urandom_range(1, 10)) begin
      kind = $urandom_range(0, 99);
      plen = 0;
      if (kind < 50) begin
        case ($urandom_range(0, 2))
          0: begin
            tag = QUAT_TAGS[3'($urandom_range(0, 5))];
            plen = 10;
          end
          1: begin
            tag = EULER_TAGS[1'($urandom_range(0, 1))];
            plen = 6;
          end
          default: begin
            tag = VECT_TAGS[5'($urandom_range(0, 24))];
            plen = 6;
          end
        endcase
      end else if (kind < 60) begin
        tag = $urandom_range(0, 1) ? TAG_SMALL0 : TAG_SMALL1;
        plen = 1;
      end else if (kind < 70) begin
        tag = $urandom_range(0, 1) ? TAG_LARGE0 : TAG_LARGE1;
        plen = 2;
      end else if (kind < 78) begin
        tag = $urandom_range(0, 1) ? TAG_FULL0 : TAG_FULL1;
        plen = 5;
      end else if (kind < 85) begin
        tag = $urandom_range(0, 1) ? TAG_META0 : TAG_META1;
        plen = 3;
      end else begin
        case ($urandom_range(0, 2))
          0:       tag = TAG_FILLER;
          1:       tag = TAG_PAD;
          default: tag = 8'($urandom_range(0, 255));
        endcase
      end
      read_bytes.push_back(tag);
      if (plen > 0) useful += 1 + plen;
      style = $urandom_range(0, 7);
      repeat (plen) begin
        case (style)
          0:       read_bytes.push_back(8'h00);
          1:       read_bytes.push_back(8'hff);
          default: read_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    if ($urandom_range(0, 5) == 0 && read_bytes.size() > 1) begin
      cut = $urandom_range(1, read_bytes.size() - 1);
      repeat (cut) void'(read_bytes.pop_back());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.sensor_id     = out_tdata[7:0];
      got.timestamp     = out_tdata[47:8];
      got.x_value       = out_tdata[63:48];
      got.y_value       = out_tdata[79:64];
      got.z_value       = out_tdata[95:80];
      got.w_value       = out_tdata[111:96];
      got.accuracy      = out_tdata[127:112];
      got.record_format = out_tuser;
      if (pending_records.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record: id %h ts %h", got.sensor_id, got.timestamp);
      end else begin
        want = pending_records.pop_front();
        if (got.sensor_id !== want.sensor_id || got.record_format !== want.record_format ||
            got.timestamp !== want.timestamp || got.x_value !== want.x_value ||
            got.y_value !== want.y_value || got.z_value !== want.z_value ||
            got.w_value !== want.w_value || got.accuracy !== want.accuracy) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: got  id %h fmt %0d ts %h x %h y %h z %h w %h acc %h",
                     got.sensor_id, got.record_format, got.timestamp, got.x_value,
                     got.y_value, got.z_value, got.w_value, got.accuracy);
            $display("          want id %h fmt %0d ts %h x %h y %h z %h w %h acc %h",
                     want.sensor_id, want.record_format, want.timestamp, want.x_value,
                     want.y_value, want.z_value, want.w_value, want.accuracy);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The long hold lets the output register and skid fill so that the input stalls.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(0, 24)) @(negedge clk);
    end
  end

  initial begin
    int useful;
    int useful_total;
    int reads;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tlast = 1'b0;
    errors = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    useful_total = 0;
    reads = 0;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      offer(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].rec);

    while (useful_total < RANDOM_BYTES) begin
      if (reads == 10) hold_req = 1'b1;
      if (reads == 20) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        while (pending_records.size() != 0) @(posedge clk);
      end
      if (useful_total > RANDOM_BYTES * 4 / 5) idle_on = 1'b0;
      build_read(useful);
      foreach (read_bytes[i])
        offer(read_bytes[i], i == read_bytes.size() - 1, 1'b0, NO_REC);
      useful_total += useful;
      reads++;
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast = 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sfrp_pkg.sv
rtl/sfrp_parser.sv
rtl/sensor_fifo_record_parser_core.sv
rtl/sfrp_checker.sv
verif/sensor_fifo_record_parser_core_tb.sv
